/* hw/rtl/fir_lowpass_filter_top_macros.svh */
// Assertion macros shared by the FIR low-pass filter RTL.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef FIR_LOWPASS_FILTER_TOP_MACROS_SVH
`define FIR_LOWPASS_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FLP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/flp_pkg.sv */
// Shared constants and types of the FIR low-pass filter.
// No dependencies; every other RTL file of the block but the macro header uses it.
`timescale 1ns / 1ps

package flp_pkg;

   localparam int MAX_TAPS    = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int VALUE_BITS  = 16;
   localparam int COEF_BITS   = 16;
   localparam int FRAC_BITS   = 15;
   localparam int IDX_BITS    = 6;
   localparam int TAPCNT_BITS = 7;
   localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS    = PROD_BITS + $clog2(MAX_TAPS);
   localparam int SHIFT_BITS  = ACC_BITS + 1 - FRAC_BITS;
   localparam int CNT_BITS    = $clog2(MAX_TAPS + 2);

   localparam int PADDR_BITS  = 3;
   localparam int PDATA_BITS  = 32;
   localparam int REGIDX_BITS = PADDR_BITS - 2;

   localparam logic [TAPCNT_BITS-1:0] TAPCNT_RESET = TAPCNT_BITS'(MAX_TAPS);
   localparam logic [CNT_BITS-1:0]    DONE_COUNT   = CNT_BITS'(MAX_TAPS + 1);

   localparam logic [ACC_BITS:0] ROUND_HALF = (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
   localparam logic signed [SHIFT_BITS-1:0] SAT_MAX =
      SHIFT_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SHIFT_BITS-1:0] SAT_MIN =
      SHIFT_BITS'(-(1 << (SAMPLE_BITS - 1)));

   // Item modes.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // Register indexes.
   localparam logic [REGIDX_BITS-1:0] REG_TAP_COUNT = REGIDX_BITS'(0);

   typedef struct packed {
      logic shift_en;
      logic load_en;
      logic tap_en;
   } cell_ctrl_type;

endpackage

/* hw/rtl/flp_req_if.sv */
// Input channel of the FIR low-pass filter: valid/ready plus the item fields.
// Depends on flp_pkg.
`timescale 1ns / 1ps

interface flp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  mode;
   logic [flp_pkg::IDX_BITS-1:0]          tap_index;
   logic signed [flp_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, mode, tap_index, value, input ready);
   modport sink   (input valid, mode, tap_index, value, output ready);
endinterface

/* hw/rtl/flp_rsp_if.sv */
// Result channel of the FIR low-pass filter: valid/ready plus the filtered sample.
// Depends on flp_pkg.
`timescale 1ns / 1ps

interface flp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [flp_pkg::SAMPLE_BITS-1:0] filtered_sample;

   modport source (output valid, filtered_sample, input ready);
   modport sink   (input valid, filtered_sample, output ready);
endinterface

/* hw/rtl/flp_tap_cell.sv */
// One tap of the filter chain: delay-line sample, coefficient, product and partial sum.
// Depends on flp_pkg.
`timescale 1ns / 1ps

module flp_tap_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  flp_pkg::cell_ctrl_type                 ctrl,
   input  logic signed [flp_pkg::SAMPLE_BITS-1:0] sample_prev,
   input  logic signed [flp_pkg::COEF_BITS-1:0]   coef_wdata,
   input  logic signed [flp_pkg::ACC_BITS-1:0]    sum_prev,
   output logic signed [flp_pkg::SAMPLE_BITS-1:0] sample_next,
   output logic signed [flp_pkg::ACC_BITS-1:0]    sum_next
);

   logic signed [flp_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [flp_pkg::COEF_BITS-1:0]   coef_ff, coef_in;
   logic signed [flp_pkg::PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [flp_pkg::ACC_BITS-1:0]    sum_ff, sum_in;

   always_comb begin
      sample_in = ctrl.shift_en ? sample_prev : sample_ff;
      coef_in   = ctrl.load_en ? coef_wdata : coef_ff;
      // Taps beyond the active count add nothing to the sum.
      prod_in   = '0;
      if (ctrl.tap_en) begin
         prod_in = coef_ff * sample_ff;
      end
      sum_in    = sum_prev + flp_pkg::ACC_BITS'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         coef_ff   <= '0;
      end else begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sample_next = sample_ff;
   assign sum_next    = sum_ff;

endmodule

/* hw/rtl/flp_csr.sv */
// APB-style register port of the FIR low-pass filter: holds the tap count.
// Depends on flp_pkg.
`timescale 1ns / 1ps

module flp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [flp_pkg::PADDR_BITS-1:0]      paddr,
   input  logic [flp_pkg::PDATA_BITS-1:0]      pwdata,
   output logic [flp_pkg::PDATA_BITS-1:0]      prdata,
   output logic                                pready,
   output logic [flp_pkg::TAPCNT_BITS-1:0]     tap_count
);

   logic [flp_pkg::TAPCNT_BITS-1:0] tap_count_ff, tap_count_in;
   logic [flp_pkg::REGIDX_BITS-1:0] reg_index;
   logic                            wr_strobe;

   assign pready    = 1'b1;
   assign reg_index = paddr[flp_pkg::PADDR_BITS-1:2];
   assign wr_strobe = psel && penable && pwrite && pready;

   always_comb begin
      tap_count_in = tap_count_ff;
      prdata       = '0;
      unique case (reg_index)
         flp_pkg::REG_TAP_COUNT: begin
            prdata = flp_pkg::PDATA_BITS'(tap_count_ff);
            if (wr_strobe) begin
               tap_count_in = pwdata[flp_pkg::TAPCNT_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= flp_pkg::TAPCNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   assign tap_count = tap_count_ff;

endmodule

/* hw/rtl/fir_lowpass_filter_top.sv */
// Top level of the FIR low-pass filter: tap-cell chain, control and result register.
// Depends on flp_pkg, flp_req_if, flp_rsp_if, flp_tap_cell, flp_csr and the macro header.
`timescale 1ns / 1ps
`include "fir_lowpass_filter_top_macros.svh"

// Direct-form FIR filter with up to 64 taps, built as a chain of 64 tap cells.
// Each cell holds one delay-line sample and one Q1.15 coefficient, multiplies
// them into a registered product and adds that product to the partial sum that
// its left neighbor hands over every cycle. A load item (mode 0) writes the
// coefficient of slot tap_index and gives no result. A sample item (mode 1)
// shifts the sample into the delay line as it is accepted; the partial sum then
// ripples down the chain, and the result leaves the last cell, is rounded to
// nearest (ties upward), saturated to 16 bits and placed in the output register.
// The block takes no new item from the acceptance of a sample item until its
// result has passed the partial-sum chain and entered the output register. A
// load item leaves the block free, so the next item can follow it at once. The
// output register parts the two sides, so a new item is accepted while a
// finished result still waits to be taken; a sample's result is held back only
// when the previous one has not yet been taken. The tap count register (byte
// address 0) selects how many cells add their product; the user must write it
// only while the block is idle; the block itself does not enforce this. Reset
// clears the delay line and coefficients to zero and sets the tap count to 64.
module fir_lowpass_filter_top (
   input  logic                               clock,
   input  logic                               reset,
   flp_req_if.sink                            req_bus,
   flp_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [flp_pkg::PADDR_BITS-1:0]     paddr,
   input  logic [flp_pkg::PDATA_BITS-1:0]     pwdata,
   output logic [flp_pkg::PDATA_BITS-1:0]     prdata,
   output logic                               pready
);

   logic [flp_pkg::TAPCNT_BITS-1:0] tap_count;

   // Handshake and control state. The block is busy from the acceptance of a
   // sample item until its result enters the output register.
   logic                          req_accept;
   logic                          sample_accept;
   logic                          load_accept;
   logic                          busy_ff, busy_in;
   logic [flp_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [flp_pkg::SAMPLE_BITS-1:0] out_data_ff, out_data_in;
   logic                          capture;

   // Chain wiring between the cells.
   flp_pkg::cell_ctrl_type                 cell_ctrl    [flp_pkg::MAX_TAPS];
   logic signed [flp_pkg::SAMPLE_BITS-1:0] sample_chain [flp_pkg::MAX_TAPS];
   logic signed [flp_pkg::ACC_BITS-1:0]    sum_chain    [flp_pkg::MAX_TAPS];

   // Rounding and saturation of the final sum.
   logic [flp_pkg::ACC_BITS:0]               round_sum;
   logic signed [flp_pkg::SHIFT_BITS-1:0]    shifted;
   logic signed [flp_pkg::SAMPLE_BITS-1:0]   saturated;

   flp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .tap_count (tap_count)
   );

   assign req_bus.ready = !busy_ff;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign sample_accept = req_accept && (req_bus.mode == flp_pkg::MODE_SAMPLE);
   assign load_accept   = req_accept && (req_bus.mode == flp_pkg::MODE_LOAD);

   // The cell chain. Cell 0 takes the new sample; every cell passes its sample
   // and partial sum to the next one. A tap count of zero still enables cell 0,
   // and a count above 64 enables every cell.
   for (genvar k = 0; k < flp_pkg::MAX_TAPS; k++) begin : g_cell
      logic signed [flp_pkg::SAMPLE_BITS-1:0] sample_prev;
      logic signed [flp_pkg::ACC_BITS-1:0]    sum_prev;

      assign cell_ctrl[k].shift_en = sample_accept;
      assign cell_ctrl[k].load_en  = load_accept &&
                                     (req_bus.tap_index == flp_pkg::IDX_BITS'(k));
      assign cell_ctrl[k].tap_en   = (k == 0) ||
                                     (flp_pkg::TAPCNT_BITS'(k) < tap_count);

      if (k == 0) begin : g_head
         assign sample_prev = req_bus.value[flp_pkg::SAMPLE_BITS-1:0];
         assign sum_prev    = '0;
      end else begin : g_body
         assign sample_prev = sample_chain[k-1];
         assign sum_prev    = sum_chain[k-1];
      end

      flp_tap_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[k]),
         .sample_prev (sample_prev),
         .coef_wdata  (req_bus.value[flp_pkg::COEF_BITS-1:0]),
         .sum_prev    (sum_prev),
         .sample_next (sample_chain[k]),
         .sum_next    (sum_chain[k])
      );
   end

   // Add one half in Q.15, then an arithmetic shift gives floor, which rounds to
   // nearest with ties toward plus infinity. The extra top bit keeps the add exact.
   always_comb begin
      round_sum = {sum_chain[flp_pkg::MAX_TAPS-1][flp_pkg::ACC_BITS-1],
                   sum_chain[flp_pkg::MAX_TAPS-1]} + flp_pkg::ROUND_HALF;
      shifted   = round_sum[flp_pkg::ACC_BITS:flp_pkg::FRAC_BITS];
      if (shifted > flp_pkg::SAT_MAX) begin
         saturated = flp_pkg::SAT_MAX[flp_pkg::SAMPLE_BITS-1:0];
      end else if (shifted < flp_pkg::SAT_MIN) begin
         saturated = flp_pkg::SAT_MIN[flp_pkg::SAMPLE_BITS-1:0];
      end else begin
         saturated = shifted[flp_pkg::SAMPLE_BITS-1:0];
      end
   end

   // The last cell's sum is complete once the count reaches the chain length
   // plus one; it moves into the output register as soon as that is free.
   assign capture = busy_ff && (count_ff == flp_pkg::DONE_COUNT) &&
                    (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      if (sample_accept) begin
         busy_in  = 1'b1;
         count_in = '0;
      end else if (capture) begin
         busy_in      = 1'b0;
         out_valid_in = 1'b1;
         out_data_in  = saturated;
      end else if (busy_ff && (count_ff != flp_pkg::DONE_COUNT)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.filtered_sample = out_data_ff;

   // A sample item starts a fresh pass down the chain.
   `FLP_ASSERT_NEXT(a_sample_starts_pass, clock, reset, sample_accept, busy_ff && (count_ff == '0), "sample item did not start a chain pass")
   // A new result appears only when the chain pass has completed.
   `FLP_ASSERT_IMPL(a_result_after_pass, clock, reset, $rose(out_valid_ff), $past(busy_ff) && ($past(count_ff) == flp_pkg::DONE_COUNT), "result captured before the chain pass completed")
   // The delay line must not move while a pass is still in flight.
   `FLP_ASSERT_IMPL(a_line_frozen, clock, reset, busy_ff && $past(busy_ff), $stable(sample_chain[0]) && $stable(sample_chain[flp_pkg::MAX_TAPS-1]), "delay line moved during a chain pass")

endmodule

/* tb/fir_lowpass_filter_checker.sv */
// Scoreboard for the FIR low-pass filter: watches both channels and the register port,
// predicts every filtered sample and compares it. Depends on flp_pkg, flp_req_if, flp_rsp_if.
`timescale 1ns / 1ps

module fir_lowpass_filter_checker
   import flp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   flp_req_if                    req_bus,
   flp_rsp_if                    rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   input  logic                  pready,
   output int                    error_count,
   output int                    outstanding
);

   logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   coefs [MAX_TAPS];
   logic [TAPCNT_BITS-1:0]        taps_setting;
   logic signed [SAMPLE_BITS-1:0] pending_samples [$];
   logic signed [SAMPLE_BITS-1:0] due_sample;
   int                            failures = 0;

   // Dot product of coefficients and history over the active taps, rounded to
   // nearest with ties upward, then clamped to the sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] filter_output();
      longint acc;
      longint rounded;
      longint sat_hi;
      longint sat_lo;
      int     n;
      sat_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      sat_lo = -sat_hi - 1;
      n = int'(taps_setting);
      if (n == 0) n = 1;
      if (n > MAX_TAPS) n = MAX_TAPS;
      acc = 0;
      for (int j = 0; j < n; j++) acc += longint'(coefs[j]) * longint'(history[j]);
      rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (rounded > sat_hi) rounded = sat_hi;
      if (rounded < sat_lo) rounded = sat_lo;
      return rounded[SAMPLE_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_TAPS; j++) begin
            history[j] = '0;
            coefs[j]   = '0;
         end
         taps_setting = TAPCNT_RESET;
         pending_samples.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[PADDR_BITS-1:2] == REG_TAP_COUNT)
            taps_setting = pwdata[TAPCNT_BITS-1:0];

         // The result leaving at this edge belongs to an earlier sample, so it is
         // checked before this edge's input item is predicted.
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_samples.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("filtered_sample %0d arrived with no sample pending",
                           rsp_bus.filtered_sample);
            end else begin
               due_sample = pending_samples.pop_front();
               if (rsp_bus.filtered_sample !== due_sample) begin
                  failures++;
                  if (failures <= 10)
                     $display("filtered_sample mismatch: expected %0d, got %0d",
                              due_sample, rsp_bus.filtered_sample);
               end
            end
         end

         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.mode == MODE_LOAD) begin
               coefs[req_bus.tap_index] = req_bus.value;
            end else begin
               for (int j = MAX_TAPS - 1; j > 0; j--) history[j] = history[j-1];
               history[0] = req_bus.value;
               pending_samples.push_back(filter_output());
            end
         end
      end
      outstanding <= pending_samples.size();
      error_count <= failures;
   end

endmodule

/* tb/fir_lowpass_filter_top_tb.sv */
// Top of the FIR low-pass filter testbench: clock, reset, stimulus and the verdict.
// Depends on flp_pkg, flp_req_if, flp_rsp_if, fir_lowpass_filter_top and the checker.
`timescale 1ns / 1ps

module fir_lowpass_filter_top_tb;
   import flp_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 2;
   // Covers the time that a sample occupies the block, with margin.
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 115;
   // The address just above the tap count register maps to no register.
   localparam logic [REGIDX_BITS-1:0] REG_UNMAPPED = REG_TAP_COUNT + 1'b1;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [PDATA_BITS-1:0] pwdata;
   logic [PDATA_BITS-1:0] prdata;
   logic                  pready;
   int                    error_count;
   int                    outstanding;
   int                    cycle_count;

   // Knobs shared between the sender and the receiver processes.
   bit quiet_run    = 1'b0;
   bit hold_request = 1'b0;
   bit sender_gaps  = 1'b1;

   flp_req_if req_bus ();
   flp_rsp_if rsp_bus ();

   fir_lowpass_filter_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   fir_lowpass_filter_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Samples lean toward the extremes and toward small values, so that both the
   // saturation paths and the rounding of small sums are exercised often.
   function automatic logic signed [VALUE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return VALUE_BITS'($signed($urandom_range(0, 511)) - 256);
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // Coefficients are mostly modest, so that a full 64-tap sum does not always
   // saturate; full-scale and zero coefficients still appear.
   function automatic logic signed [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         3, 4:    return COEF_BITS'($urandom);
         5, 6:    return COEF_BITS'($signed($urandom_range(0, 2047)) - 1024);
         default: return COEF_BITS'($signed($urandom_range(0, 127)) - 64);
      endcase
   endfunction

   // Offers one item and waits for its handshake. Afterward the sender may drop
   // valid for a random burst; otherwise valid stays high for the next item.
   task automatic send_item(input logic mode, input logic [IDX_BITS-1:0] slot,
                            input logic signed [VALUE_BITS-1:0] val);
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.tap_index <= slot;
      req_bus.value     <= val;
      do @(posedge clock); while (!req_bus.ready);
      if (!quiet_run && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Stops offering items and waits until every predicted sample has come back.
   // The loop waits on the clock before it tests, so valid never gets two assignments in one step.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Register writes happen only on an idle block: after the results are drained,
   // a further pause lets any load item still inside the block settle.
   task automatic write_register(input logic [REGIDX_BITS-1:0] index,
                                 input logic [PDATA_BITS-1:0] data);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Only the low bits hold the tap count; the upper bits are random noise.
   task automatic set_tap_count(input int setting);
      logic [PDATA_BITS-1:0] data;
      data = $urandom;
      data[TAPCNT_BITS-1:0] = TAPCNT_BITS'(setting);
      write_register(REG_TAP_COUNT, data);
   endtask

   // A well-formed phase: load a coefficient set (often the whole table), then
   // stream samples with an occasional coefficient update mixed in.
   task automatic run_phase(input int budget);
      int sent;
      sent = 0;
      if ($urandom_range(0, 1) == 1) begin
         for (int slot = 0; slot < MAX_TAPS; slot++) begin
            send_item(MODE_LOAD, IDX_BITS'(slot), pick_coef());
            sent++;
         end
      end else begin
         repeat (8) begin
            send_item(MODE_LOAD, IDX_BITS'($urandom_range(0, MAX_TAPS - 1)), pick_coef());
            sent++;
         end
      end
      while (sent < budget) begin
         if ($urandom_range(0, 7) == 0)
            send_item(MODE_LOAD, IDX_BITS'($urandom_range(0, MAX_TAPS - 1)), pick_coef());
         else
            send_item(MODE_SAMPLE, IDX_BITS'($urandom), pick_sample());
         sent++;
      end
   endtask

   // Receiver: random stalls between bursts of readiness, long
   // stretches of steady readiness now and then, a long hold-off on request, and
   // no stalls at all once the quiet tail of the run begins.
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (quiet_run) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(20, 200)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("fir_lowpass_filter_top_tb failed");
      $finish;
   end

   initial begin
      int tap_settings [] = '{64, 1, 0, 127, 65, 2, 17, 33, 48, 5, 64};

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.mode      <= MODE_LOAD;
      req_bus.tap_index <= '0;
      req_bus.value     <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset tap count of 64.
      // Start-up: coefficients and history are zero, so even full scale gives zero.
      send_item(MODE_SAMPLE, '0, 16'sh7FFF);
      // Extreme coefficients, including the last slot of the table.
      send_item(MODE_LOAD, 6'd0, 16'sh8000);
      send_item(MODE_LOAD, 6'd1, 16'sh7FFF);
      send_item(MODE_LOAD, 6'd63, 16'sh7FFF);
      // Both products large and positive: the sum saturates upward. The tap index
      // of a sample item carries no meaning and is set to all ones here.
      send_item(MODE_SAMPLE, 6'd63, 16'sh8000);
      // Both products large and negative: the sum saturates downward.
      send_item(MODE_SAMPLE, '0, 16'sh7FFF);
      // With a one-half coefficient on the newest sample only, odd samples land
      // exactly halfway and must round toward plus infinity.
      send_item(MODE_LOAD, 6'd0, 16'sh4000);
      send_item(MODE_LOAD, 6'd1, 16'sh0000);
      send_item(MODE_SAMPLE, '0, 16'sh0001);
      send_item(MODE_SAMPLE, '0, 16'shFFFF);
      send_item(MODE_SAMPLE, '0, 16'sh0003);
      send_item(MODE_SAMPLE, '0, 16'shFFFD);
      send_item(MODE_SAMPLE, '0, 16'sh0000);
      send_item(MODE_SAMPLE, '0, 16'sh0000);

      // Random part: one phase per tap count setting (two for the fourth), covering
      // one tap, a count of zero (treated as one tap), counts above the table size
      // (clipped to 64) and ordinary counts. Each change reuses the history held.
      foreach (tap_settings[k]) begin
         set_tap_count(tap_settings[k]);
         sender_gaps = ($urandom_range(0, 3) != 0);
         run_phase(PHASE_ITEMS);
         if (k == 3) begin
            // A write to an address with no register behind it must change nothing.
            write_register(REG_UNMAPPED, $urandom);
            run_phase(PHASE_ITEMS);
         end
         if (k == 6) begin
            // The receiver holds off for a long stretch while samples keep coming,
            // so finished results back up and the block stalls its input.
            sender_gaps  = 1'b0;
            hold_request = 1'b1;
            repeat (16) send_item(MODE_SAMPLE, IDX_BITS'($urandom), pick_sample());
            // Then the sender pauses until every result has been delivered.
            drain_results();
            sender_gaps = 1'b1;
         end
      end

      // Quiet tail: neither side idles.
      quiet_run = 1'b1;
      run_phase(PHASE_ITEMS);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("fir_lowpass_filter_top_tb passed");
      else
         $display("fir_lowpass_filter_top_tb failed");
      $finish;
   end

endmodule
